// ----- rtl/core/vmrab_pkg.sv -----
// Package: shared constants, opcodes and controller/datapath command types.
`timescale 1ns / 1ps
package vmrab_pkg;
    localparam int NUM_REGS_DEF = 16;
    localparam int XLEN = 64;

    localparam logic [7:0] OP_MOV  = 8'h01;
    localparam logic [7:0] OP_NEG  = 8'h02;
    localparam logic [7:0] OP_CMP  = 8'h03;
    localparam logic [7:0] OP_ADD  = 8'h04;
    localparam logic [7:0] OP_SUB  = 8'h05;
    localparam logic [7:0] OP_MUL  = 8'h06;
    localparam logic [7:0] OP_DIV  = 8'h07;
    localparam logic [7:0] OP_MOD  = 8'h08;
    localparam logic [7:0] OP_AND  = 8'h09;
    localparam logic [7:0] OP_OR   = 8'h0a;
    localparam logic [7:0] OP_XOR  = 8'h0b;
    localparam logic [7:0] OP_NOT  = 8'h0c;
    localparam logic [7:0] OP_NAND = 8'h0d;
    localparam logic [7:0] OP_NOR  = 8'h0e;
    localparam logic [7:0] OP_XNOR = 8'h0f;
    localparam logic [7:0] OP_INC  = 8'h10;
    localparam logic [7:0] OP_DEC  = 8'h11;
    localparam logic [7:0] OP_SHL  = 8'h12;
    localparam logic [7:0] OP_SHR  = 8'h13;
    localparam logic [7:0] OP_LDI  = 8'h18;
    localparam logic [7:0] OP_LDP  = 8'h19;
    localparam logic [7:0] OP_JMP  = 8'h30;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_UNSUP = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture instruction, read operands
        logic exec;      // execute non-iterative ops, start iterative unit
        logic iter;      // one multiply/divide step
        logic finish;    // write back the destination register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic multi;     // op needs the iterative unit
        logic iter_last; // last iteration step
    } dp_status_t;
endpackage

// ----- rtl/core/vmrab_datapath.sv -----
// Datapath: register file, flags, ALU, shift-add multiplier and restoring divider.
`timescale 1ns / 1ps
module vmrab_datapath #(
    parameter int NUM_REGS = vmrab_pkg::NUM_REGS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vmrab_pkg::dp_cmd_t   cmd,
    output vmrab_pkg::dp_status_t status,
    input  logic [31:0]          instr_word,
    input  logic [31:0]          cur_pos,
    output logic [31:0]          next_pos,
    output logic [31:0]          next_segment,
    output logic                 branch_taken,
    output logic                 halted,
    output logic [1:0]           error_code,
    output logic [3:0]           flag_bits
);
    import vmrab_pkg::*;

    logic [XLEN-1:0] regs_reg [NUM_REGS];
    logic [3:0]  flags_reg;
    logic [31:0] word_reg, pos_reg;
    logic [XLEN-1:0] x_reg, y_reg;
    logic [XLEN-1:0] res_reg;
    logic        wr_reg;
    logic        skip_reg;
    logic [XLEN-1:0] acc_reg, sh_reg, rem_reg;
    logic [6:0]  cnt_reg;

    logic [7:0] op, fa, fb, fc;
    assign op = word_reg[31:24];
    assign fa = word_reg[23:16];
    assign fb = word_reg[15:8];
    assign fc = word_reg[7:0];

    // slice read: zero-extended field of the selected register
    function automatic logic [XLEN-1:0] slice_get(logic [XLEN-1:0] v, logic [7:0] r);
        logic [XLEN-1:0] t;
        if (r[3:0] == 4'he) t = v;
        else if (r[3:2] == 2'b11) t = {32'd0, v[{r[0], 5'd0} +: 32]};
        else if (r[3]) t = {48'd0, v[{r[1:0], 4'd0} +: 16]};
        else t = {56'd0, v[{r[2:0], 3'd0} +: 8]};
        return t;
    endfunction

    function automatic logic [XLEN-1:0] slice_put(logic [XLEN-1:0] v, logic [7:0] r,
                                                  logic [XLEN-1:0] w);
        logic [XLEN-1:0] t;
        t = v;
        if (r[3:0] == 4'he) t = w;
        else if (r[3:2] == 2'b11) t[{r[0], 5'd0} +: 32] = w[31:0];
        else if (r[3]) t[{r[1:0], 4'd0} +: 16] = w[15:0];
        else t[{r[2:0], 3'd0} +: 8] = w[7:0];
        return t;
    endfunction

    logic [7:0] iw_op;
    assign iw_op = instr_word[31:24];
    logic is_div;
    assign is_div = (op == OP_DIV) || (op == OP_MOD);
    assign status.multi = !skip_reg && ((op == OP_MUL) || (is_div && y_reg != '0));
    assign status.iter_last = (cnt_reg == 7'd1);

    // destination selector
    logic [7:0] dst;
    always_comb begin
        case (op)
            OP_MOV, OP_NEG, OP_NOT, OP_INC, OP_DEC: dst = fb;
            default: dst = fc;
        endcase
    end

    // combinational result and effects
    logic [XLEN-1:0] alu_v;
    logic alu_wr;
    logic [3:0] flags_nx;
    logic [1:0] err_nx;
    logic taken_nx;
    logic [31:0] seg_nx, npos_nx;
    logic [XLEN-1:0] brreg;
    assign brreg = regs_reg[fa[7:4]];
    always_comb begin
        alu_v = '0;
        alu_wr = 1'b1;
        flags_nx = flags_reg;
        err_nx = ERR_NONE;
        taken_nx = 1'b0;
        seg_nx = '0;
        npos_nx = pos_reg + 32'd4;
        case (op)
            OP_MOV:  alu_v = x_reg;
            OP_NEG:  alu_v = '0 - x_reg;
            OP_ADD:  alu_v = x_reg + y_reg;
            OP_SUB:  alu_v = x_reg - y_reg;
            OP_AND:  alu_v = x_reg & y_reg;
            OP_OR:   alu_v = x_reg | y_reg;
            OP_XOR:  alu_v = x_reg ^ y_reg;
            OP_NOT:  alu_v = ~x_reg;
            OP_NAND: alu_v = ~(x_reg & y_reg);
            OP_NOR:  alu_v = ~(x_reg | y_reg);
            OP_XNOR: alu_v = ~(x_reg ^ y_reg);
            OP_INC:  alu_v = x_reg + 64'd1;
            OP_DEC:  alu_v = x_reg - 64'd1;
            OP_SHL:  alu_v = fb[7:6] != 2'd0 ? '0 : x_reg << fb[5:0];
            OP_SHR:  alu_v = fb[7:6] != 2'd0 ? '0 : x_reg >> fb[5:0];
            OP_LDI:  alu_v = {48'd0, fa, fb};
            OP_LDP:  alu_v = {32'd0, pos_reg + {16'd0, fa, fb}};
            OP_MUL, OP_DIV, OP_MOD: begin
                alu_wr = 1'b0;
                if (y_reg == '0 && is_div) begin
                    err_nx = ERR_DIV0;
                    npos_nx = pos_reg;
                end
            end
            OP_CMP: begin
                alu_wr = 1'b0;
                flags_nx = {flags_reg[3], x_reg > y_reg, x_reg < y_reg, x_reg == y_reg};
            end
            default: begin
                alu_wr = 1'b0;
                if (op[7:3] == 5'b00100) begin
                    flags_nx[op[2:1]] = op[0];
                end else if (op[7:3] == 5'b00101 && op[2:0] != 3'd7) begin
                    err_nx = ERR_UNSUP;
                    npos_nx = pos_reg;
                end else if (op[7:3] == 5'b00110) begin
                    if (op == OP_JMP || (flags_reg[2:0] & op[2:0]) != 3'd0) begin
                        taken_nx = 1'b1;
                        seg_nx = brreg[{fa[0], 5'd0} +: 32];
                        npos_nx = y_reg[31:0];
                    end
                end
            end
        endcase
        if (skip_reg) begin
            alu_wr = 1'b0;
            flags_nx = flags_reg;
            err_nx = ERR_NONE;
            taken_nx = 1'b0;
            seg_nx = '0;
            npos_nx = pos_reg;
        end
    end

    // iterative unit: shift-add multiply / restoring divide, one bit per cycle
    logic [XLEN:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, sh_reg[XLEN-1]};
    assign rem_sub = rem_sh - {1'b0, y_reg};

    logic [XLEN-1:0] wval;
    assign wval = (op == OP_MUL) ? acc_reg : (op == OP_DIV ? sh_reg : rem_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) regs_reg[i] <= '0;
            flags_reg <= '0;
        end else begin
            if (cmd.load) begin
                word_reg <= instr_word;
                pos_reg  <= cur_pos;
                x_reg    <= slice_get(regs_reg[instr_word[23:20]], instr_word[23:16]);
                y_reg    <= slice_get(regs_reg[instr_word[15:12]], instr_word[15:8]);
                skip_reg <= flags_reg[3];
                if (iw_op == 8'h00) wr_reg <= 1'b0;
            end
            if (cmd.exec) begin
                res_reg      <= alu_v;
                wr_reg       <= alu_wr;
                flags_reg    <= flags_nx;
                error_code   <= err_nx;
                branch_taken <= taken_nx;
                next_segment <= seg_nx;
                next_pos     <= npos_nx;
                halted       <= flags_nx[3];
                flag_bits    <= flags_nx;
                cnt_reg      <= 7'd64;
                acc_reg      <= '0;
                rem_reg      <= '0;
                sh_reg       <= (op == OP_MUL) ? y_reg : x_reg;
            end
            if (cmd.iter) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (op == OP_MUL) begin
                    acc_reg <= sh_reg[XLEN-1] ? {acc_reg[XLEN-2:0], 1'b0} + x_reg
                                              : {acc_reg[XLEN-2:0], 1'b0};
                    sh_reg  <= {sh_reg[XLEN-2:0], 1'b0};
                end else if (!rem_sub[XLEN]) begin
                    rem_reg <= rem_sub[XLEN-1:0];
                    sh_reg  <= {sh_reg[XLEN-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[XLEN-1:0];
                    sh_reg  <= {sh_reg[XLEN-2:0], 1'b0};
                end
            end
            if (cmd.finish && !skip_reg) begin
                if (wr_reg)
                    regs_reg[dst[7:4]] <= slice_put(regs_reg[dst[7:4]], dst, res_reg);
                else if (status.multi)
                    regs_reg[dst[7:4]] <= slice_put(regs_reg[dst[7:4]], dst, wval);
            end
        end
    end
endmodule

// ----- rtl/core/vmrab_ctrl.sv -----
// Controller: sequences load, execute, iterate and write-back per transaction.
`timescale 1ns / 1ps
module vmrab_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vmrab_pkg::dp_cmd_t    cmd,
    input  vmrab_pkg::dp_status_t status
);
    import vmrab_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_ITER, S_FIN, S_OUT} state_t;
    state_t state_reg;

    // result holds in the output register until taken; a new one may enter then
    assign s_ready = (state_reg == S_IDLE) || (state_reg == S_OUT && m_ready);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        cmd = '0;
        cmd.load   = s_valid && s_ready;
        cmd.exec   = (state_reg == S_EXEC);
        cmd.iter   = (state_reg == S_ITER);
        cmd.finish = (state_reg == S_FIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: if (s_valid) state_reg <= S_EXEC;
                S_EXEC: state_reg <= status.multi ? S_ITER : S_FIN;
                S_ITER: if (status.iter_last) state_reg <= S_FIN;
                S_FIN:  state_reg <= S_OUT;
                S_OUT: begin
                    if (m_ready) state_reg <= s_valid ? S_EXEC : S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/vm_register_alu_branch_core.sv -----
// Top level: register ALU and branch core with valid/ready channels.
`timescale 1ns / 1ps
// One instruction per transaction. Most ops go through operand read, execute
// and write back before a valid result; multiply, divide and modulo with a
// nonzero divisor also run a one-bit-per-cycle shift unit. The next
// instruction is accepted in the cycle its predecessor's result is taken.
// Registers and flags reset to zero; results carry next position, segment,
// branch, halt, error and flags after the step.
module vm_register_alu_branch_core #(
    parameter int NUM_REGS = vmrab_pkg::NUM_REGS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instr_word,
    input  logic [31:0] s_cur_pos,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pos,
    output logic [31:0] m_next_segment,
    output logic        m_branch_taken,
    output logic        m_halted,
    output logic [1:0]  m_error_code,
    output logic [3:0]  m_flag_bits
);
    import vmrab_pkg::*;
    dp_cmd_t    cmd;
    dp_status_t status;

    vmrab_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .status(status)
    );

    vmrab_datapath #(.NUM_REGS(NUM_REGS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .instr_word(s_instr_word), .cur_pos(s_cur_pos),
        .next_pos(m_next_pos), .next_segment(m_next_segment),
        .branch_taken(m_branch_taken), .halted(m_halted),
        .error_code(m_error_code), .flag_bits(m_flag_bits)
    );
endmodule
